[rtl/assert_macros.svh]
// Assertion macros for the FFT RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`endif

[rtl/r2fft_pkg.sv]
`timescale 1ns / 1ps
// Package for the radix-2 FFT: data types, twiddle table, saturation helpers.
// No dependencies.
package r2fft_pkg;
  typedef logic signed [23:0] data_t;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_WRA  = 3'd3;
  localparam logic [2:0] ST_WRB  = 3'd4;
  localparam logic [2:0] ST_OUTR = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  function automatic logic signed [15:0] qcos(input logic [4:0] m);
    logic signed [15:0] r;
    case (m)
      5'd0: r = 16'sd32767;  5'd1: r = 16'sd32610;  5'd2: r = 16'sd32138;
      5'd3: r = 16'sd31357;  5'd4: r = 16'sd30274;  5'd5: r = 16'sd28899;
      5'd6: r = 16'sd27246;  5'd7: r = 16'sd25330;  5'd8: r = 16'sd23170;
      5'd9: r = 16'sd20788;  5'd10: r = 16'sd18205; 5'd11: r = 16'sd15447;
      5'd12: r = 16'sd12540; 5'd13: r = 16'sd9512;  5'd14: r = 16'sd6393;
      5'd15: r = 16'sd3212;  default: r = 16'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] cos64(input logic [5:0] m);
    logic signed [15:0] r;
    if (m <= 6'd16) r = qcos(m[4:0]);
    else if (m <= 6'd32) r = -qcos(5'(6'd32 - m));
    else if (m <= 6'd48) r = -qcos(5'(m - 6'd32));
    else r = qcos(5'(7'd64 - {1'b0, m}));
    return r;
  endfunction

  function automatic data_t sat24(input logic signed [41:0] v);
    data_t r;
    if (v > 42'sd8388607) r = 24'sh7fffff;
    else if (v < -42'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction
endpackage

[rtl/radix2_complex_fft_top.sv]
`timescale 1ns / 1ps
// Iterative radix-2 DIT FFT, POINTS complex samples per frame.
// Load: one item per cycle while not busy; samples go to bit-reversed addresses
// of one store. Compute: one shared butterfly, stepped through read, multiply,
// write p and write q, as the single store write port takes one write at a time;
// then the unload, one result per cycle. Reset clears control; store undefined.
`include "assert_macros.svh"
module radix2_complex_fft_top import r2fft_pkg::*; #(
  parameter int POINTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        direction_we_i,
  input  logic        direction_i,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  output logic        strobe,
  output logic signed [23:0] out_re_o,
  output logic signed [23:0] out_im_o,
  output logic [5:0]  out_index_o,
  output logic        out_last_o
);
  localparam int LG = $clog2(POINTS);
  localparam int AW = LG;

  logic [2:0] st_q, st_d;
  logic direction_q, dir_frame_q;
  logic [AW-1:0] cnt_q;       // load / unload position
  logic [AW-2:0] bf_q;        // butterfly number within a pass
  logic [$clog2(LG)-1:0] pass_q; // pass index
  logic [AW-1:0] pa, qa, rev;
  logic [AW-1:0] pa_nxt;      // p address of the following butterfly
  logic [5:0] tw_m;
  logic accept;

  // Store: one write port, registered read
  logic [47:0] mem [POINTS];
  logic [47:0] rd_q;
  logic [AW-1:0] wa, ra;
  logic [47:0] wd;
  logic we;
  logic [47:0] a_hold_q;

  data_t pr, pi, qr, qi;
  logic signed [15:0] tw_c, tw_s;

  // take an item only when the block is free
  assign accept = start && !busy;

  always_comb begin
    for (int b = 0; b < AW; b++) rev[b] = cnt_q[AW-1-b];
  end

  // pair addresses: insert a 0/1 bit at position pass into the butterfly number
  always_comb begin
    logic [AW-1:0] hmask;
    logic [AW-1:0] ext;
    hmask = AW'((1 << pass_q) - 1);
    ext = AW'({1'b0, bf_q});
    pa = (ext & hmask) | ((ext & ~hmask) << 1);
    qa = pa | AW'(1 << pass_q);
    tw_m = 6'(((ext & hmask) * (64 >> (pass_q + 1))));
  end

  assign tw_c = cos64(tw_m);
  assign tw_s = dir_frame_q ? -cos64(tw_m + 6'd48) : cos64(tw_m + 6'd48);

  always_comb begin
    we = 1'b0;
    wa = pa;
    wd = {pr, pi};
    ra = pa;
    unique case (st_q)
      ST_LOAD: begin
        we = accept;
        wa = rev;
        wd = {24'(sample_re_i), 24'(sample_im_i)};
      end
      ST_RD:   ra = qa;
      ST_WRA:  begin we = 1'b1; wa = pa; wd = {pr, pi}; end
      ST_WRB:  begin we = 1'b1; wa = qa; wd = {qr, qi}; ra = pa_nxt; end
      ST_OUTR, ST_OUT: ra = cnt_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
    if (st_q == ST_RD) a_hold_q <= rd_q;
  end

  r2fft_bfly u_bfly (
    .clk_i, .en_i(st_q == ST_CALC),
    .ar_i(a_hold_q[47:24]), .ai_i(a_hold_q[23:0]),
    .br_i(rd_q[47:24]), .bi_i(rd_q[23:0]),
    .c_i(tw_c), .s_i(tw_s),
    .pr_o(pr), .pi_o(pi), .qr_o(qr), .qi_o(qi)
  );

  // ST_RD issues read of q after the read of p issued in the prior state
  logic last_bf, last_pass, last_cnt;
  assign last_bf = (bf_q == {(AW-1){1'b1}});
  assign last_pass = (32'(pass_q) == LG - 1);
  assign last_cnt = (cnt_q == {AW{1'b1}});

  // p address of the butterfly that follows the current one
  always_comb begin
    logic [AW-1:0] nmask;
    logic [AW-1:0] next_ext;
    logic [$clog2(LG)-1:0] npass;
    npass = last_bf ? (last_pass ? '0 : pass_q + 1'b1) : pass_q;
    nmask = AW'((1 << npass) - 1);
    next_ext = AW'({1'b0, bf_q + 1'b1});
    pa_nxt = (next_ext & nmask) | ((next_ext & ~nmask) << 1);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_LOAD: if (accept && last_cnt) st_d = ST_RD;
      ST_RD:   st_d = ST_CALC;
      ST_CALC: st_d = ST_WRA;
      ST_WRA:  st_d = ST_WRB;
      ST_WRB:  st_d = (last_bf && last_pass) ? ST_OUTR : ST_RD;
      ST_OUTR: st_d = ST_OUT;
      ST_OUT:  if (cnt_q == '0) st_d = ST_LOAD;
      default: st_d = ST_LOAD;
    endcase
  end

  // ST_RD needs p read the cycle before: issue it in the preceding state
  // (ST_LOAD final, ST_WRB). Those states drive ra=pa of the next pair.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD;
      cnt_q <= '0;
      bf_q <= '0;
      pass_q <= '0;
      direction_q <= 1'b0;
      dir_frame_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (direction_we_i) direction_q <= direction_i;
      unique case (st_q)
        ST_LOAD: if (accept) begin
          cnt_q <= cnt_q + 1'b1;
          if (last_cnt) dir_frame_q <= direction_q;
        end
        ST_WRB: begin
          bf_q <= bf_q + 1'b1;
          if (last_bf) pass_q <= last_pass ? '0 : pass_q + 1'b1;
        end
        ST_OUTR: cnt_q <= cnt_q + 1'b1;
        // hold at zero after the final entry so the next load starts there
        ST_OUT:  if (cnt_q != '0) cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  // p read issue: ST_LOAD reads pa of the first pair (address 0), ST_WRB
  // reads pa_nxt, the p address of the pair that follows.

  // Unload: cnt_q leads the registered read by one
  logic [AW-1:0] oidx_q;
  logic ovalid_q;
  data_t ore, oim;
  always_comb begin
    logic signed [41:0] vr, vi;
    vr = 42'(signed'(rd_q[47:24])) + 42'(POINTS / 2);
    vi = 42'(signed'(rd_q[23:0])) + 42'(POINTS / 2);
    if (dir_frame_q) begin
      ore = sat24(vr >>> LG);
      oim = sat24(vi >>> LG);
    end else begin
      ore = rd_q[47:24];
      oim = rd_q[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      oidx_q <= '0;
    end else begin
      ovalid_q <= (st_q == ST_OUT);
      oidx_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_re_o <= ore;
    out_im_o <= oim;
  end

  assign strobe = ovalid_q;
  assign out_index_o = 6'(oidx_q);
  assign out_last_o = ovalid_q && (oidx_q == {AW{1'b1}});
  assign busy = (st_q != ST_LOAD) || ovalid_q;

  `ASSERT_NEVER(a_strobe_in_load, clk_i, rst_ni, strobe && start && !busy)
  `ASSERT_IMPL(a_last_ends, clk_i, rst_ni, out_last_o |=> !strobe)
  `ASSERT_IMPL(a_bfly_counts, clk_i, rst_ni, (st_q == ST_LOAD) |-> (bf_q == '0 && pass_q == '0))
endmodule

[rtl/r2fft_bfly.sv]
`timescale 1ns / 1ps
// Butterfly datapath: registered twiddle product, then sum and difference.
// Depends on r2fft_pkg.
module r2fft_bfly import r2fft_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  data_t              ar_i,
  input  data_t              ai_i,
  input  data_t              br_i,
  input  data_t              bi_i,
  input  logic signed [15:0] c_i,
  input  logic signed [15:0] s_i,
  output data_t              pr_o,
  output data_t              pi_o,
  output data_t              qr_o,
  output data_t              qi_o
);
  logic signed [40:0] tr_full, ti_full;
  data_t tr_q, ti_q, ar_q, ai_q;

  assign tr_full = 41'(br_i) * 41'(c_i) - 41'(bi_i) * 41'(s_i) + 41'sd16384;
  assign ti_full = 41'(br_i) * 41'(s_i) + 41'(bi_i) * 41'(c_i) + 41'sd16384;

  // hold product until the writes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tr_q <= sat24(42'(tr_full >>> 15));
      ti_q <= sat24(42'(ti_full >>> 15));
      ar_q <= ar_i;
      ai_q <= ai_i;
    end
  end

  assign pr_o = sat24(42'(ar_q) + 42'(tr_q));
  assign pi_o = sat24(42'(ai_q) + 42'(ti_q));
  assign qr_o = sat24(42'(ar_q) - 42'(tr_q));
  assign qi_o = sat24(42'(ai_q) - 42'(ti_q));
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the radix-2 complex FFT: streams sample frames, predicts
// every transform result in a scoreboard class and compares each strobed result.
// Depends on r2fft_pkg and radix2_complex_fft_top.
module tb_top;
  import r2fft_pkg::*;

  localparam int NPTS = 64;
  localparam int LOG2N = 6;
  localparam int TAIL_CYCLES = 2 * NPTS * LOG2N + NPTS + 64;

  typedef struct {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [5:0]         index;
    logic               last;
  } fft_bin_t;

  // Frame collector and transform predictor; expected bins wait in a queue.
  class fft_scoreboard;
    logic signed [23:0] frame_re[NPTS];
    logic signed [23:0] frame_im[NPTS];
    int unsigned        fill;
    bit                 inverse;
    fft_bin_t           pending_bins[$];
    int unsigned        errors;

    function void set_direction(bit d);
      inverse = d;
    endfunction

    function longint quarter_cos(int m);
      int tbl[17];
      tbl = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
              20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
      m = m & 63;
      if (m <= 16) return tbl[m];
      if (m <= 32) return -tbl[32 - m];
      if (m <= 48) return -tbl[m - 32];
      return tbl[64 - m];
    endfunction

    function longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    // Arithmetic shift on longint floors, matching the rounding rule.
    function longint round_q15(longint p);
      return clip24((p + 16384) >>> 15);
    endfunction

    // Note one accepted sample; on the final one of a frame, predict all bins.
    function void note_sample(logic signed [15:0] sre, logic signed [15:0] sim);
      longint wr[NPTS], wi[NPTS];
      longint c, s, br, bi, tr, ti, ar, ai, vr, vi;
      int rev, p, q, half, stride;
      fft_bin_t b;
      frame_re[fill] = 24'(sre);
      frame_im[fill] = 24'(sim);
      fill++;
      if (fill < NPTS) return;
      fill = 0;
      for (int i = 0; i < NPTS; i++) begin
        rev = 0;
        for (int k = 0; k < LOG2N; k++)
          if ((i >> k) & 1) rev |= 1 << (LOG2N - 1 - k);
        wr[rev] = longint'(frame_re[i]);
        wi[rev] = longint'(frame_im[i]);
      end
      for (int len = 2; len <= NPTS; len <<= 1) begin
        half = len / 2;
        stride = 64 / len;
        for (int k = 0; k < NPTS; k += len) begin
          for (int j = 0; j < half; j++) begin
            c = quarter_cos(j * stride);
            s = quarter_cos(j * stride + 48);
            if (inverse) s = -s;
            p = k + j;
            q = k + j + half;
            br = wr[q]; bi = wi[q]; ar = wr[p]; ai = wi[p];
            tr = round_q15(br * c - bi * s);
            ti = round_q15(br * s + bi * c);
            wr[p] = clip24(ar + tr); wi[p] = clip24(ai + ti);
            wr[q] = clip24(ar - tr); wi[q] = clip24(ai - ti);
          end
        end
      end
      for (int i = 0; i < NPTS; i++) begin
        vr = wr[i];
        vi = wi[i];
        if (inverse) begin
          vr = clip24((vr + NPTS / 2) >>> LOG2N);
          vi = clip24((vi + NPTS / 2) >>> LOG2N);
        end
        b.re = vr[23:0];
        b.im = vi[23:0];
        b.index = i[5:0];
        b.last = (i == NPTS - 1);
        pending_bins.push_back(b);
      end
    endfunction

    function void check_bin(fft_bin_t got);
      fft_bin_t want;
      if (pending_bins.size() == 0) begin
        $error("unexpected result at index %0d", got.index);
        errors++;
        return;
      end
      want = pending_bins.pop_front();
      if (got.re !== want.re) begin
        $error("out_re: expected %0d, actual %0d", want.re, got.re); errors++;
      end
      if (got.im !== want.im) begin
        $error("out_im: expected %0d, actual %0d", want.im, got.im); errors++;
      end
      if (got.index !== want.index) begin
        $error("out_index: expected %0d, actual %0d", want.index, got.index); errors++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0d, actual %0d", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic direction_we_i = 1'b0;
  logic direction_i = 1'b0;
  logic signed [15:0] sample_re_i = '0;
  logic signed [15:0] sample_im_i = '0;
  logic strobe;
  logic signed [23:0] out_re_o, out_im_o;
  logic [5:0] out_index_o;
  logic out_last_o;

  fft_scoreboard fft_sb = new();
  bit quiet_stretch;

  always #5 clk_i = ~clk_i;

  radix2_complex_fft_top #(.POINTS(NPTS)) i_dut (
    .clk_i, .rst_ni, .start, .busy, .direction_we_i, .direction_i,
    .sample_re_i, .sample_im_i, .strobe, .out_re_o, .out_im_o,
    .out_index_o, .out_last_o
  );

  // Sample each strobed result at the rising edge; the receiver never stalls.
  always @(posedge clk_i) begin
    fft_bin_t got;
    if (rst_ni && strobe) begin
      got.re = out_re_o;
      got.im = out_im_o;
      got.index = out_index_o;
      got.last = out_last_o;
      fft_sb.check_bin(got);
    end
  end

  // Write the direction register while idle; both model and block take it.
  task automatic write_direction(bit d);
    start <= 1'b0;
    direction_i <= d;
    direction_we_i <= 1'b1;
    @(negedge clk_i);
    direction_we_i <= 1'b0;
    fft_sb.set_direction(d);
  endtask

  // Offer one sample and hold start until the block takes it; idle at random.
  task automatic send_sample(logic signed [15:0] sre, logic signed [15:0] sim);
    bit accepted;
    while (!quiet_stretch && $urandom_range(99) < 24) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    sample_re_i <= sre;
    sample_im_i <= sim;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk_i);
      accepted = !busy;
      @(negedge clk_i);
    end
    fft_sb.note_sample(sre, sim);
  endtask

  // Hold off until every predicted bin has arrived, then let the block settle.
  task automatic drain_results();
    start <= 1'b0;
    while (fft_sb.pending_bins.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_sample(int style);
    case (style)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(255) - 128);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_frame(int style);
    for (int i = 0; i < NPTS; i++)
      send_sample(rand_sample(style == 4 ? $urandom_range(3) : style),
                  rand_sample(style == 4 ? $urandom_range(3) : style));
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Inverse frame of mixed full-scale and random samples, no idling at all.
    write_direction(1'b1);
    quiet_stretch = 1'b1;
    send_frame(4);
    quiet_stretch = 1'b0;
    drain_results();

    // Direction flip mid-frame: the value at the final sample rules the frame.
    for (int i = 0; i < NPTS / 2; i++) send_sample(rand_sample(3), rand_sample(3));
    write_direction(1'b0);
    for (int i = 0; i < NPTS / 2; i++) send_sample(rand_sample(3), rand_sample(3));

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fft_sb.errors == 0 && fft_sb.pending_bins.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/r2fft_pkg.sv
rtl/r2fft_bfly.sv
rtl/radix2_complex_fft_top.sv
tb/tb_top.sv
